// File: hw/rtl/elementary_cellular_automaton_step_macros.svh
// Assertion macros for the cellular automaton step RTL.
`ifndef ELEMENTARY_CELLULAR_AUTOMATON_STEP_MACROS_SVH
`define ELEMENTARY_CELLULAR_AUTOMATON_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ECAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ECAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ecas_pkg.sv
// Shared types and constants for the cellular automaton step block.
`timescale 1ns / 1ps
package ecas_pkg;

  localparam int WORD_W      = 64;  // chunk_bits / row_bits width
  localparam int MAX_CHUNKS  = 4;
  localparam int CHUNK_IDX_W = 2;
  localparam int RULE_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int MIN_CELLS   = 3;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd2;

  typedef struct packed {
    logic load;     // write one chunk into the row
    logic step;     // advance the row one generation, restart chunk counter
    logic advance;  // move to the next output chunk
  } ecas_cmd_t;

  typedef struct packed {
    logic last;     // current output chunk is the final one
  } ecas_status_t;

endpackage

// File: hw/rtl/ecas_if.sv
// Handshake channel interfaces: input items, result items, register writes.
`timescale 1ns / 1ps
interface ecas_in_if
  import ecas_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [CHUNK_IDX_W-1:0] chunk_index;
  logic [WORD_W-1:0]      chunk_bits;

  modport source (output valid, output op, output chunk_index, output chunk_bits,
                  input ready);
  modport sink   (input valid, input op, input chunk_index, input chunk_bits,
                  output ready);
endinterface

interface ecas_out_if
  import ecas_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [WORD_W-1:0]      row_bits;
  logic [CHUNK_IDX_W-1:0] chunk_number;
  logic                   last;

  modport source (output valid, output row_bits, output chunk_number, output last,
                  input ready);
  modport sink   (input valid, input row_bits, input chunk_number, input last,
                  output ready);
endinterface

interface ecas_cfg_if
  import ecas_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/elementary_cellular_automaton_step.sv
// Top level of the elementary cellular automaton step block.
`timescale 1ns / 1ps
// Holds a row of binary cells and advances it one generation of an
// elementary cellular automaton (Wolfram rule numbering). A load item
// (op 0) writes one chunk of CHUNK_WIDTH cells and gives no result. A
// step item (op 1) updates every cell of the row in the cycle it is
// accepted: each cell takes bit {left,self,right} of rule_number,
// with the row ends wrapping (periodic) or seeing zero (boundary_closed).
// The new row then leaves as ceil(n/CHUNK_WIDTH) result items, chunk 0
// first, last set on the final one, where n is cell_count clamped to
// 3..min(MAX_CELLS, 4*CHUNK_WIDTH), 4 chunks at the default sizes. The
// single result port carries one chunk per cycle while out_chan.ready is
// high. No new item is taken while chunks are pending; the next one is
// taken the cycle after the last chunk is accepted. Cells at or past n
// are cleared by a step and read as zero. Configuration writes are always
// taken and must only be issued while the block is idle.
module elementary_cellular_automaton_step
  import ecas_pkg::*;
#(
  parameter int MAX_CELLS   = 256,
  parameter int CHUNK_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ecas_in_if.sink    in_chan,
  ecas_out_if.source out_chan,
  ecas_cfg_if.sink   cfg_chan
);

  // row length limit: storage size or four chunks, whichever is smaller
  localparam int CELL_LIMIT = (MAX_CELLS < MAX_CHUNKS * CHUNK_WIDTH) ?
                              MAX_CELLS : MAX_CHUNKS * CHUNK_WIDTH;

  logic [RULE_W-1:0]  rule_r;
  logic               closed_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] used_count;
  logic               cfg_fire;
  ecas_cmd_t          cmd;
  ecas_status_t       status;

  // register writes
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r   <= RULE_W'(110);
      closed_r <= 1'b0;
      count_r  <= COUNT_W'(256);
    end else if (cfg_fire) begin
      case (cfg_chan.index)
        REG_RULE:     rule_r   <= cfg_chan.data[RULE_W-1:0];
        REG_BOUNDARY: closed_r <= cfg_chan.data[0];
        REG_COUNT:    count_r  <= cfg_chan.data[COUNT_W-1:0];
        default: ;    // unused index: write dropped
      endcase
    end
  end

  // cells in use, clamped to the legal range
  always_comb begin
    used_count = count_r;
    if (32'(count_r) > 32'(CELL_LIMIT)) begin
      used_count = COUNT_W'(CELL_LIMIT);
    end else if (32'(count_r) < 32'(MIN_CELLS)) begin
      used_count = COUNT_W'(MIN_CELLS);
    end
  end

  ecas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ecas_dp #(
    .MAX_CELLS   (MAX_CELLS),
    .CHUNK_WIDTH (CHUNK_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .chunk_index     (in_chan.chunk_index),
    .chunk_bits      (in_chan.chunk_bits),
    .rule_number     (rule_r),
    .boundary_closed (closed_r),
    .used_count      (used_count),
    .row_bits        (out_chan.row_bits),
    .chunk_number    (out_chan.chunk_number),
    .status          (status)
  );

  assign out_chan.last = status.last;

endmodule

// File: hw/rtl/ecas_ctrl.sv
// Controller: accepts items and sequences the chunk emission after a step.
`timescale 1ns / 1ps
`include "elementary_cellular_automaton_step_macros.svh"
module ecas_ctrl
  import ecas_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_op,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ecas_status_t status,
  output ecas_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic in_fire, out_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    cmd.load    = in_fire && (in_op == OP_LOAD);
    cmd.step    = in_fire && (in_op == OP_STEP);
    cmd.advance = out_fire && !status.last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_STEP)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ECAS_ASSERT_NOW(a_no_overlap, 1'b1, !(in_ready && out_valid), "input taken while emitting")
  `ECAS_ASSERT_NEXT(a_step_emits, in_valid && in_ready && in_op == OP_STEP, out_valid, "step gave no output")
  `ECAS_ASSERT_NEXT(a_load_silent, in_valid && in_ready && in_op == OP_LOAD, in_ready, "load started output")
  `ECAS_ASSERT_NEXT(a_last_frees, out_valid && out_ready && status.last, in_ready && !out_valid, "no return to idle after last chunk")

endmodule

// File: hw/rtl/ecas_dp.sv
// Datapath: cell row, generation update, chunk counter and output mux.
`timescale 1ns / 1ps
module ecas_dp
  import ecas_pkg::*;
#(
  parameter int MAX_CELLS   = 256,
  parameter int CHUNK_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ecas_cmd_t              cmd,
  input  logic [CHUNK_IDX_W-1:0] chunk_index,
  input  logic [WORD_W-1:0]      chunk_bits,
  input  logic [RULE_W-1:0]      rule_number,
  input  logic                   boundary_closed,
  input  logic [COUNT_W-1:0]     used_count,
  output logic [WORD_W-1:0]      row_bits,
  output logic [CHUNK_IDX_W-1:0] chunk_number,
  output ecas_status_t           status
);

  localparam int ROW_IDX_W = $clog2(MAX_CELLS);

  logic [MAX_CELLS-1:0]   row_r, row_nxt, next_gen;
  logic [CHUNK_IDX_W-1:0] chunk_r, chunk_nxt;
  logic [31:0]            last_cell;
  logic                   wrap_left, wrap_right;
  logic [WORD_W-1:0]      chunk_words [MAX_CHUNKS];

  // neighbours seen across the row ends
  assign last_cell  = 32'(used_count) - 32'd1;
  assign wrap_left  = boundary_closed ? 1'b0 : row_r[last_cell[ROW_IDX_W-1:0]];
  assign wrap_right = boundary_closed ? 1'b0 : row_r[0];

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    localparam int CK = i / CHUNK_WIDTH;
    logic l, r, in_use, load_hit;

    if (i == 0) begin : g_l0
      assign l = wrap_left;
    end else begin : g_ln
      assign l = row_r[i-1];
    end

    if (i + 1 < MAX_CELLS) begin : g_rn
      assign r = (32'(i) == last_cell) ? wrap_right : row_r[i+1];
    end else begin : g_rl
      assign r = wrap_right;
    end

    assign in_use      = (32'(i) < 32'(used_count));
    assign next_gen[i] = in_use ? rule_number[{l, row_r[i], r}] : 1'b0;

    if (CK < MAX_CHUNKS) begin : g_ld
      assign load_hit = cmd.load && (chunk_index == CHUNK_IDX_W'(CK));
      assign row_nxt[i] = cmd.step ? next_gen[i] :
                          load_hit ? chunk_bits[i % CHUNK_WIDTH] : row_r[i];
    end else begin : g_nld
      assign load_hit   = 1'b0;
      assign row_nxt[i] = cmd.step ? next_gen[i] : row_r[i];
    end
  end

  // output chunk words; cells past the row read as zero
  for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_chunk
    for (genvar j = 0; j < WORD_W; j++) begin : g_bit
      if (j < CHUNK_WIDTH && k * CHUNK_WIDTH + j < MAX_CELLS) begin : g_on
        assign chunk_words[k][j] = row_r[k*CHUNK_WIDTH+j];
      end else begin : g_off
        assign chunk_words[k][j] = 1'b0;
      end
    end
  end

  always_comb begin
    chunk_nxt = chunk_r;
    if (cmd.step) begin
      chunk_nxt = '0;
    end else if (cmd.advance) begin
      chunk_nxt = chunk_r + CHUNK_IDX_W'(1);
    end
  end

  assign row_bits     = chunk_words[chunk_r];
  assign chunk_number = chunk_r;
  assign status.last  = ((32'(chunk_r) + 32'd1) * 32'(CHUNK_WIDTH)) >= 32'(used_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      chunk_r <= '0;
    end else begin
      row_r   <= row_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule
